### src/pfa_pkg.sv
// shared constants, codes and types of the page frame allocator
package pfa_pkg;

    // table geometry
    localparam int NUM_PAGES = 4096;
    localparam int REF_BITS  = 8;
    localparam int ADDR_W    = $clog2(NUM_PAGES);
    localparam int TOTAL_W   = $clog2(NUM_PAGES + 1);

    // port field widths
    localparam int PAGE_W   = 12;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 8;
    localparam int FREE_W   = 13;

    localparam logic [PAGE_W-1:0] FIRST_PAGE_RESET = 12'd256;

    // refs entry: free mark on top of the count
    localparam int REF_ENTRY_W = REF_BITS + 1;

    // opcodes
    localparam logic [OP_W-1:0] OP_INIT  = 3'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 3'd1;
    localparam logic [OP_W-1:0] OP_FREE  = 3'd2;
    localparam logic [OP_W-1:0] OP_INC   = 3'd3;
    localparam logic [OP_W-1:0] OP_DEC   = 3'd4;
    localparam logic [OP_W-1:0] OP_QUERY = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DOUBLE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SAT    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ZERO   = 3'd5;

    // controller states
    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_SWEEP  = 6'b000100,
        S_FLUSH  = 6'b001000,
        S_LOOKUP = 6'b010000,
        S_EXEC   = 6'b100000
    } state_t;

    // operands of the update step
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [PAGE_W-1:0]   pg;
        logic [PAGE_W-1:0]   first_page;
        logic                mark;
        logic [REF_BITS-1:0] cnt;
        logic [ADDR_W-1:0]   nxt;
        logic [ADDR_W-1:0]   head;
        logic                head_valid;
        logic [TOTAL_W-1:0]  total;
    } exec_in_t;

    // results and write-backs of the update step
    typedef struct packed {
        logic [PAGE_W-1:0]      res_page;
        logic [STATUS_W-1:0]    status;
        logic [COUNT_W-1:0]     count_out;
        logic                   pushed;
        logic                   ref_we;
        logic [ADDR_W-1:0]      ref_addr;
        logic [REF_ENTRY_W-1:0] ref_wdata;
        logic                   next_we;
        logic [ADDR_W-1:0]      next_addr;
        logic [ADDR_W-1:0]      next_wdata;
        logic [ADDR_W-1:0]      head_next;
        logic                   head_valid_next;
        logic [TOTAL_W-1:0]     total_next;
    } exec_out_t;

endpackage

### src/pfa_ram.sv
// generic single-port-write, single-port-read ram with registered read
module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/pfa_exec.sv
// update step: decodes one operation against the entries read from the tables
module pfa_exec
    import pfa_pkg::*;
(
    input  exec_in_t  ei,
    output exec_out_t eo
);

    localparam logic [REF_BITS-1:0] REF_MAX = '1;
    localparam logic [REF_BITS-1:0] REF_ONE = REF_BITS'(1);

    logic                in_range;
    logic                init_fill;
    logic [ADDR_W-1:0]   pg_addr;
    logic [TOTAL_W-1:0]  total_dec;

    assign in_range  = 32'(ei.pg) < 32'(NUM_PAGES);
    assign init_fill = 32'(ei.first_page) < 32'(NUM_PAGES);
    assign pg_addr   = ADDR_W'(ei.pg);
    assign total_dec = ei.total - TOTAL_W'(1);

    always_comb
    begin
        eo                 = '0;
        eo.res_page        = ei.pg;
        eo.status          = ST_OK;
        eo.ref_addr        = pg_addr;
        eo.next_addr       = pg_addr;
        eo.head_next       = ei.head;
        eo.head_valid_next = ei.head_valid;
        eo.total_next      = ei.total;

        unique case (ei.op)
            // tables already rebuilt by the sweep, set the list registers
            OP_INIT:
            begin
                eo.count_out       = in_range ? COUNT_W'(ei.cnt) : '0;
                eo.head_next       = init_fill ? ADDR_W'(NUM_PAGES - 1) : '0;
                eo.head_valid_next = init_fill;
                eo.total_next      = init_fill ?
                                     TOTAL_W'(NUM_PAGES - 32'(ei.first_page)) : '0;
            end
            // pop the head
            OP_ALLOC:
            begin
                if (!ei.head_valid || ei.total == '0)
                begin
                    eo.status   = ST_EMPTY;
                    eo.res_page = '0;
                end
                else
                begin
                    eo.total_next      = total_dec;
                    eo.ref_we          = 1'b1;
                    eo.ref_addr        = ei.head;
                    eo.ref_wdata       = {1'b0, REF_ONE};
                    eo.head_next       = (total_dec != '0) ? ei.nxt : '0;
                    eo.head_valid_next = (total_dec != '0);
                    eo.res_page        = PAGE_W'(ei.head);
                    eo.count_out       = COUNT_W'(REF_ONE);
                end
            end
            // push or drop one reference
            OP_FREE:
            begin
                if (!in_range || ei.pg < ei.first_page)
                begin
                    eo.status = ST_RANGE;
                end
                else if (ei.mark)
                begin
                    eo.status    = ST_DOUBLE;
                    eo.count_out = COUNT_W'(ei.cnt);
                end
                else if (ei.cnt <= REF_ONE)
                begin
                    eo.next_we         = 1'b1;
                    eo.next_wdata      = ei.head_valid ? ei.head : '0;
                    eo.ref_we          = 1'b1;
                    eo.ref_wdata       = {1'b1, ei.cnt};
                    eo.head_next       = pg_addr;
                    eo.head_valid_next = 1'b1;
                    eo.total_next      = ei.total + TOTAL_W'(1);
                    eo.pushed          = 1'b1;
                    eo.count_out       = COUNT_W'(ei.cnt);
                end
                else
                begin
                    eo.ref_we    = 1'b1;
                    eo.ref_wdata = {1'b0, ei.cnt - REF_ONE};
                    eo.count_out = COUNT_W'(ei.cnt - REF_ONE);
                end
            end
            // saturating increment
            OP_INC:
            begin
                if (!in_range)
                begin
                    eo.status = ST_RANGE;
                end
                else if (ei.cnt == REF_MAX)
                begin
                    eo.status    = ST_SAT;
                    eo.count_out = COUNT_W'(ei.cnt);
                end
                else
                begin
                    eo.ref_we    = 1'b1;
                    eo.ref_wdata = {ei.mark, ei.cnt + REF_ONE};
                    eo.count_out = COUNT_W'(ei.cnt + REF_ONE);
                end
            end
            // decrement that stops at zero
            OP_DEC:
            begin
                if (!in_range)
                begin
                    eo.status = ST_RANGE;
                end
                else if (ei.cnt == '0)
                begin
                    eo.status = ST_ZERO;
                end
                else
                begin
                    eo.ref_we    = 1'b1;
                    eo.ref_wdata = {ei.mark, ei.cnt - REF_ONE};
                    eo.count_out = COUNT_W'(ei.cnt - REF_ONE);
                end
            end
            OP_QUERY:
            begin
                if (!in_range)
                begin
                    eo.status = ST_RANGE;
                end
                else
                begin
                    eo.count_out = COUNT_W'(ei.cnt);
                end
            end
            default:
            begin
                eo.count_out = '0;
            end
        endcase
    end

endmodule

### src/page_frame_allocator_refcount.sv
// Page frame allocator with per-page reference counts. Free pages form a LIFO
// list whose links sit in one synchronous ram, while the counts and free marks
// share a second ram; head, valid flag and free total are registers. Every
// operation but init reads the addressed entry and the link under the head as
// it is taken, then updates and writes back; a new word is taken only after
// that update, which waits until the previous result word has left the output
// register; a stalled result word holds the update step and with it the input.
// Init sweeps the count ram one page a cycle (read, then rewrite in the cycle
// after), then passes a flush and a lookup state before its update step. After
// reset a clearing pass zeroes the count ram, during which no input word is
// taken; writes to first_page are accepted at any time.
module page_frame_allocator_refcount
    import pfa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [PAGE_W-1:0]   cfg_data,
    // input channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [OP_W-1:0]     opcode,
    input  logic [PAGE_W-1:0]   page_number,
    // output channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic [PAGE_W-1:0]   result_page,
    output logic [STATUS_W-1:0] status,
    output logic [COUNT_W-1:0]  ref_count_out,
    output logic [FREE_W-1:0]   pages_free,
    output logic                pushed
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_PAGES - 1);

    state_t                 state_reg, state_next;
    logic [PAGE_W-1:0]      first_page_reg;
    logic [OP_W-1:0]        op_reg;
    logic [PAGE_W-1:0]      pg_reg;
    logic [ADDR_W-1:0]      head_reg;
    logic                   head_valid_reg;
    logic [TOTAL_W-1:0]     total_reg;
    logic [ADDR_W-1:0]      sweep_addr_reg;
    logic                   wr_pend_reg;
    logic [ADDR_W-1:0]      wr_addr_reg;
    logic                   out_valid_reg;
    logic [PAGE_W-1:0]      res_page_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic [TOTAL_W-1:0]     free_reg;
    logic                   pushed_reg;

    logic                   in_accept;
    logic                   exec_go;
    logic                   sweep_last;
    logic                   wr_fill;
    exec_in_t               ei;
    exec_out_t              eo;

    logic                   ref_we, ref_re;
    logic [ADDR_W-1:0]      ref_waddr, ref_raddr;
    logic [REF_ENTRY_W-1:0] ref_wdata, ref_rdata;
    logic                   next_we, next_re;
    logic [ADDR_W-1:0]      next_waddr, next_raddr;
    logic [ADDR_W-1:0]      next_wdata, next_rdata;

    // handshakes
    assign cfg_ready  = 1'b1;
    assign in_stall   = (state_reg != S_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign exec_go    = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);
    assign sweep_last = (sweep_addr_reg == LAST_ADDR);
    assign wr_fill    = 32'(wr_addr_reg) >= 32'(first_page_reg);

    // update step operands
    always_comb
    begin
        ei.op         = op_reg;
        ei.pg         = pg_reg;
        ei.first_page = first_page_reg;
        ei.mark       = ref_rdata[REF_BITS];
        ei.cnt        = ref_rdata[REF_BITS-1:0];
        ei.nxt        = next_rdata;
        ei.head       = head_reg;
        ei.head_valid = head_valid_reg;
        ei.total      = total_reg;
    end

    pfa_exec u_exec (
        .ei (ei),
        .eo (eo)
    );

    // count ram port control
    always_comb
    begin
        ref_we    = 1'b0;
        ref_waddr = eo.ref_addr;
        ref_wdata = eo.ref_wdata;
        ref_re    = 1'b0;
        ref_raddr = ADDR_W'(page_number);
        unique case (state_reg)
            S_CLEAR:
            begin
                ref_we    = 1'b1;
                ref_waddr = sweep_addr_reg;
                ref_wdata = '0;
            end
            S_IDLE:
            begin
                ref_re = in_accept;
            end
            S_SWEEP, S_FLUSH:
            begin
                ref_we    = wr_pend_reg;
                ref_waddr = wr_addr_reg;
                ref_wdata = wr_fill ? {1'b1, REF_BITS'(1)}
                                    : {1'b0, ref_rdata[REF_BITS-1:0]};
                ref_re    = (state_reg == S_SWEEP);
                ref_raddr = sweep_addr_reg;
            end
            S_LOOKUP:
            begin
                ref_re    = 1'b1;
                ref_raddr = ADDR_W'(pg_reg);
            end
            S_EXEC:
            begin
                ref_we = exec_go && eo.ref_we;
            end
            default:
            begin
                ref_we = 1'b0;
            end
        endcase
    end

    // link ram port control
    always_comb
    begin
        next_we    = 1'b0;
        next_waddr = eo.next_addr;
        next_wdata = eo.next_wdata;
        next_re    = in_accept;
        next_raddr = head_reg;
        if (state_reg == S_SWEEP || state_reg == S_FLUSH)
        begin
            next_we    = wr_pend_reg && wr_fill;
            next_waddr = wr_addr_reg;
            next_wdata = (32'(wr_addr_reg) == 32'(first_page_reg)) ? '0
                                                                  : wr_addr_reg - 1'b1;
        end
        else if (state_reg == S_EXEC)
        begin
            next_we = exec_go && eo.next_we;
        end
    end

    pfa_ram #(
        .WIDTH (REF_ENTRY_W),
        .DEPTH (NUM_PAGES)
    ) u_ref_ram (
        .clk   (clk),
        .we    (ref_we),
        .waddr (ref_waddr),
        .wdata (ref_wdata),
        .re    (ref_re),
        .raddr (ref_raddr),
        .rdata (ref_rdata)
    );

    pfa_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (NUM_PAGES)
    ) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .re    (next_re),
        .raddr (next_raddr),
        .rdata (next_rdata)
    );

    // controller next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (opcode == OP_INIT) ? S_SWEEP : S_EXEC;
                end
            end
            S_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                state_next = S_LOOKUP;
            end
            S_LOOKUP:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            first_page_reg <= FIRST_PAGE_RESET;
            head_reg       <= '0;
            head_valid_reg <= 1'b0;
            total_reg      <= '0;
            sweep_addr_reg <= '0;
            wr_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wr_pend_reg <= (state_reg == S_SWEEP);
            if (cfg_valid && cfg_ready)
            begin
                first_page_reg <= cfg_data;
            end
            if (state_reg == S_CLEAR || state_reg == S_SWEEP)
            begin
                sweep_addr_reg <= sweep_last ? '0 : sweep_addr_reg + 1'b1;
            end
            if (exec_go)
            begin
                head_reg       <= eo.head_next;
                head_valid_reg <= eo.head_valid_next;
                total_reg      <= eo.total_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg <= opcode;
            pg_reg <= page_number;
        end
        wr_addr_reg <= sweep_addr_reg;
        if (exec_go)
        begin
            res_page_reg <= eo.res_page;
            status_reg   <= eo.status;
            count_reg    <= eo.count_out;
            free_reg     <= eo.total_next;
            pushed_reg   <= eo.pushed;
        end
    end

    // output word
    assign out_valid     = out_valid_reg;
    assign result_page   = res_page_reg;
    assign status        = status_reg;
    assign ref_count_out = count_reg;
    assign pages_free    = FREE_W'(free_reg);
    assign pushed        = pushed_reg;

endmodule

### src/pfa_checker.sv
// port-level checks of the page frame allocator and their bind
module pfa_checker
    import pfa_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic [PAGE_W-1:0]   result_page,
    input logic [STATUS_W-1:0] status,
    input logic [COUNT_W-1:0]  ref_count_out,
    input logic [FREE_W-1:0]   pages_free,
    input logic                pushed
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_page) && $stable(status)
                                   && $stable(ref_count_out) && $stable(pages_free))
    else $error("stalled result word changed");

    // one word at a time: the input stalls right after a word is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("input taken on two consecutive cycles");

    // a push leaves at least one page on the list and reports success
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pushed |-> status == ST_OK && pages_free != '0)
    else $error("push reported with bad status or empty list");

    // an empty-list alloc reports page zero and count zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> result_page == '0 && ref_count_out == '0
                                            && !pushed)
    else $error("empty alloc result malformed");

endmodule

bind page_frame_allocator_refcount pfa_checker u_pfa_checker (.*);

### tb/tb_page_frame_allocator_refcount.sv
// testbench for the page frame allocator: directed and random words checked against a predictor
`timescale 1ns / 1ps

module tb_page_frame_allocator_refcount
    import pfa_pkg::*;
();

    // opcodes the block leaves unused
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    localparam logic [PAGE_W-1:0]   TOP_PAGE   = PAGE_W'(NUM_PAGES - 1);
    localparam logic [REF_BITS-1:0] REF_TOP    = '1;
    localparam int                  IDLE_LIMIT = 20000;
    localparam int                  SHOWN_MAX  = 10;

    // one result word as seen on the output port
    typedef struct packed {
        logic [PAGE_W-1:0]   page;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic [FREE_W-1:0]   free;
        logic                pushed;
    } frame_result_t;

    // predicted page tables plus the results still owed by the block
    class frame_ledger;
        logic [REF_BITS-1:0] refs[NUM_PAGES];
        bit                  marks[NUM_PAGES];
        logic [PAGE_W-1:0]   links[NUM_PAGES];
        logic [PAGE_W-1:0]   head;
        bit                  head_ok;
        int unsigned         total;
        logic [PAGE_W-1:0]   first_page;
        frame_result_t       due[$];
        int unsigned         checked;
        int unsigned         bad;
        int unsigned         shown;
        int unsigned         status_hits[8];

        function new();
            for (int i = 0; i < NUM_PAGES; i++)
            begin
                refs[i]  = '0;
                marks[i] = 1'b0;
                links[i] = '0;
            end
            head       = '0;
            head_ok    = 1'b0;
            total      = 0;
            first_page = FIRST_PAGE_RESET;
            checked    = 0;
            bad        = 0;
            shown      = 0;
            foreach (status_hits[i])
                status_hits[i] = 0;
        endfunction

        // put a page on top of the free list
        function void push_free(logic [PAGE_W-1:0] p);
            links[p] = head_ok ? head : '0;
            head     = p;
            head_ok  = 1'b1;
            marks[p] = 1'b1;
            total++;
        endfunction

        // apply one accepted word and queue the result it must give
        // (a 12-bit page is always below NUM_PAGES, so no upper range check)
        function void note_word(logic [OP_W-1:0] op, logic [PAGE_W-1:0] pg);
            frame_result_t r;
            int unsigned   p;
            r.page   = pg;
            r.status = ST_OK;
            r.count  = '0;
            r.pushed = 1'b0;
            case (op)
                OP_INIT:
                begin
                    foreach (marks[i])
                        marks[i] = 1'b0;
                    head_ok = 1'b0;
                    head    = '0;
                    total   = 0;
                    for (p = first_page; p < NUM_PAGES; p++)
                    begin
                        refs[p] = 1;
                        push_free(PAGE_W'(p));
                    end
                    r.count = COUNT_W'(refs[pg]);
                end
                OP_ALLOC:
                begin
                    if (!head_ok || total == 0)
                    begin
                        r.status = ST_EMPTY;
                        r.page   = '0;
                    end
                    else
                    begin
                        p = head;
                        total--;
                        marks[p] = 1'b0;
                        refs[p]  = 1;
                        if (total != 0)
                            head = links[p];
                        else
                        begin
                            head    = '0;
                            head_ok = 1'b0;
                        end
                        r.page  = PAGE_W'(p);
                        r.count = 1;
                    end
                end
                OP_FREE:
                begin
                    if (pg < first_page)
                        r.status = ST_RANGE;
                    else if (marks[pg])
                    begin
                        r.status = ST_DOUBLE;
                        r.count  = COUNT_W'(refs[pg]);
                    end
                    else if (refs[pg] <= 1)
                    begin
                        push_free(pg);
                        r.pushed = 1'b1;
                        r.count  = COUNT_W'(refs[pg]);
                    end
                    else
                    begin
                        refs[pg]--;
                        r.count = COUNT_W'(refs[pg]);
                    end
                end
                OP_INC:
                begin
                    if (refs[pg] == REF_TOP)
                        r.status = ST_SAT;
                    else
                        refs[pg]++;
                    r.count = COUNT_W'(refs[pg]);
                end
                OP_DEC:
                begin
                    if (refs[pg] == 0)
                        r.status = ST_ZERO;
                    else
                        refs[pg]--;
                    r.count = COUNT_W'(refs[pg]);
                end
                OP_QUERY:
                    r.count = COUNT_W'(refs[pg]);
                default:
                    ;
            endcase
            r.free = FREE_W'(total);
            due.push_back(r);
        endfunction

        // compare one delivered word with the oldest owed result
        function void check_result(frame_result_t got);
            frame_result_t want;
            if (due.size() == 0)
            begin
                bad++;
                if (shown < SHOWN_MAX)
                begin
                    shown++;
                    $display("tb: unexpected result page %0d status %0d count %0d free %0d",
                             got.page, got.status, got.count, got.free);
                end
                return;
            end
            want = due.pop_front();
            checked++;
            status_hits[want.status]++;
            if (got.page !== want.page || got.status !== want.status ||
                got.count !== want.count || got.free !== want.free ||
                got.pushed !== want.pushed)
            begin
                bad++;
                if (shown < SHOWN_MAX)
                begin
                    shown++;
                    $display("tb: result %0d mismatch: page %0d/%0d status %0d/%0d",
                             checked, want.page, got.page, want.status, got.status);
                    $display("tb:   count %0d/%0d free %0d/%0d pushed %0d/%0d (expected/actual)",
                             want.count, got.count, want.free, got.free,
                             want.pushed, got.pushed);
                end
            end
        endfunction
    endclass

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                cfg_valid   = 1'b0;
    logic                cfg_ready;
    logic [PAGE_W-1:0]   cfg_data    = '0;
    logic                in_valid    = 1'b0;
    logic                in_stall;
    logic [OP_W-1:0]     opcode      = OP_INIT;
    logic [PAGE_W-1:0]   page_number = '0;
    logic                out_valid;
    logic                out_stall   = 1'b0;
    logic [PAGE_W-1:0]   result_page;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  ref_count_out;
    logic [FREE_W-1:0]   pages_free;
    logic                pushed;

    frame_ledger ledger = new();

    int                burst_left  = 0;
    int                words_sent  = 0;
    int                inits_sent  = 0;
    int                settings    = 0;
    logic [PAGE_W-1:0] fp_now      = FIRST_PAGE_RESET;
    int                stall_mode  = 0;
    int                stall_left  = 0;
    int                run_left    = 0;
    bit                run_high    = 1'b0;
    int                idle_cycles = 0;

    page_frame_allocator_refcount u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .page_number   (page_number),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_page   (result_page),
        .status        (status),
        .ref_count_out (ref_count_out),
        .pages_free    (pages_free),
        .pushed        (pushed)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // result check, then next receiver stall from a pattern that changes mode now and then
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            ledger.check_result(frame_result_t'({result_page, status, ref_count_out,
                                                 pages_free, pushed}));
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(3, 0);
            stall_left = $urandom_range(200, 32);
        end
        else
            stall_left--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(3, 0) == 0);
            2: out_stall <= ($urandom_range(3, 0) != 0);
            default:
            begin
                if (run_left == 0)
                begin
                    run_left = $urandom_range(12, 1);
                    run_high = !run_high;
                end
                else
                    run_left--;
                out_stall <= run_high;
            end
        endcase
    end

    // cycles in a row with no handshake on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // watchdog
    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("tb: no handshake for %0d cycles, giving up", IDLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // send one word, opening a new burst after a random gap when the last one ran out
    task automatic send_word(input logic [OP_W-1:0] op, input logic [PAGE_W-1:0] pg);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(24, 1);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        page_number <= pg;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ledger.note_word(op, pg);
        burst_left--;
        words_sent++;
        if (op == OP_INIT)
            inits_sent++;
    endtask

    // stop sending and wait until every owed result has come back
    task automatic drain();
        if (in_valid)
            in_valid <= 1'b0;
        burst_left = 0;
        while (ledger.due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // change first_page with the block idle
    task automatic write_first_page(input logic [PAGE_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        ledger.first_page = value;
        fp_now = value;
        settings++;
    endtask

    // random mix: mostly alloc/free traffic on pages near the top of the list
    task automatic random_traffic(input int n, input logic [PAGE_W-1:0] window_lo);
        int                pick;
        logic [OP_W-1:0]   op;
        logic [PAGE_W-1:0] pg;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 1)
                op = OP_INIT;
            else if (pick < 31)
                op = OP_ALLOC;
            else if (pick < 56)
                op = OP_FREE;
            else if (pick < 70)
                op = OP_INC;
            else if (pick < 80)
                op = OP_DEC;
            else if (pick < 92)
                op = OP_QUERY;
            else if (pick < 96)
                op = OP_SPARE_LO;
            else
                op = OP_SPARE_HI;
            pick = $urandom_range(99, 0);
            if (pick < 70)
                pg = PAGE_W'($urandom_range(NUM_PAGES - 1, window_lo));
            else if (pick < 85 && fp_now != 0)
                pg = PAGE_W'($urandom_range(fp_now - 1, 0));
            else
                pg = PAGE_W'($urandom_range(NUM_PAGES - 1, 0));
            send_word(op, pg);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // empty list, range checks, double free, shared free, unused opcodes
        send_word(OP_ALLOC, '0);
        send_word(OP_QUERY, '0);
        send_word(OP_DEC, '0);
        send_word(OP_INC, TOP_PAGE);
        send_word(OP_FREE, '0);
        send_word(OP_FREE, FIRST_PAGE_RESET - 1);
        send_word(OP_FREE, FIRST_PAGE_RESET);
        send_word(OP_FREE, FIRST_PAGE_RESET);
        send_word(OP_ALLOC, '0);
        send_word(OP_INC, FIRST_PAGE_RESET);
        send_word(OP_FREE, FIRST_PAGE_RESET);
        send_word(OP_FREE, FIRST_PAGE_RESET);
        send_word(OP_ALLOC, TOP_PAGE);
        send_word(OP_SPARE_LO, 12'haaa);
        send_word(OP_SPARE_HI, 12'h555);
        send_word(OP_FREE, TOP_PAGE);
        send_word(OP_DEC, TOP_PAGE);
        send_word(OP_INIT, TOP_PAGE);
        send_word(OP_ALLOC, '0);
        send_word(OP_QUERY, TOP_PAGE);

        // single-page list
        write_first_page(TOP_PAGE);
        send_word(OP_INIT, '0);
        send_word(OP_ALLOC, '0);
        send_word(OP_ALLOC, '0);
        send_word(OP_FREE, TOP_PAGE);
        send_word(OP_FREE, TOP_PAGE - 1);
        send_word(OP_ALLOC, '0);

        // count up to saturation on a page below first_page, then back off
        for (int k = 0; k < REF_TOP + 2; k++)
            send_word(OP_INC, 12'd100);
        send_word(OP_DEC, 12'd100);
        send_word(OP_FREE, 12'd100);
        send_word(OP_QUERY, 12'd100);

        // small list: empty list and double frees come often
        write_first_page(TOP_PAGE - 15);
        send_word(OP_INIT, TOP_PAGE);
        random_traffic(220, TOP_PAGE - 23);

        // every page on the list
        write_first_page('0);
        send_word(OP_INIT, '0);
        send_word(OP_FREE, '0);
        random_traffic(200, 12'd4000);

        // random first_page
        write_first_page(PAGE_W'($urandom_range(4090, 3900)));
        send_word(OP_INIT, fp_now);
        random_traffic(170, fp_now - 8);

        // highest first_page again
        write_first_page(TOP_PAGE);
        send_word(OP_INIT, TOP_PAGE);
        random_traffic(50, TOP_PAGE - 7);

        drain();
        $display("tb: %0d words (%0d init) over %0d first_page settings, %0d results checked",
                 words_sent, inits_sent, settings + 1, ledger.checked);
        $display("tb: ok %0d, empty %0d, range %0d, double free %0d, saturated %0d, zero %0d",
                 ledger.status_hits[ST_OK], ledger.status_hits[ST_EMPTY],
                 ledger.status_hits[ST_RANGE], ledger.status_hits[ST_DOUBLE],
                 ledger.status_hits[ST_SAT], ledger.status_hits[ST_ZERO]);
        if (ledger.bad == 0 && ledger.due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
